// ===== rtl/hotkey_sequence_matcher_macros.svh =====
// assertion macros for the hotkey sequence matcher port checker
`ifndef HOTKEY_SEQUENCE_MATCHER_MACROS_SVH
`define HOTKEY_SEQUENCE_MATCHER_MACROS_SVH

// same-cycle implication, held off while reset is asserted
`define HSM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hotkey_sequence_matcher: port check failed");

// next-cycle implication, held off while reset is asserted
`define HSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hotkey_sequence_matcher: port check failed");

`endif

// ===== rtl/hsm_pkg.sv =====
// types and constants shared by the hotkey sequence matcher
`default_nettype none

package hsm_pkg;

  // fixed payload widths
  localparam int unsigned REQ_TYPE_W  = 2;
  localparam int unsigned KEY_W       = 10;
  localparam int unsigned STAMP_W     = 32;
  localparam int unsigned ENTRY_W     = 4;
  localparam int unsigned POS_W       = 3;
  localparam int unsigned VALUE_W     = 10;
  localparam int unsigned TIMEOUT_W   = 16;
  localparam int unsigned HIT_INDEX_W = 4;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;

  // widest internal fields carried between modules
  localparam int unsigned CNT_MAX_W = 6;
  localparam int unsigned ENT_MAX_W = 8;

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_FRAME = 2'd0,
    REQ_KEY   = 2'd1,
    REQ_LEN   = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_REPLY
  } hsm_state_e;

  typedef struct packed {
    logic                 start;
    logic [CNT_MAX_W-1:0] count;
    logic                 len_we;
    logic [ENT_MAX_W-1:0] len_idx;
    logic [CNT_MAX_W-1:0] len_val;
  } walk_ctl_t;

  typedef struct packed {
    logic                 done;
    logic                 hit;
    logic [ENT_MAX_W-1:0] hit_idx;
  } walk_sts_t;

endpackage

`default_nettype wire

// ===== rtl/hsm_intf.sv =====
// channel interfaces of the hotkey sequence matcher
`default_nettype none

interface hsm_req_if import hsm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [REQ_TYPE_W-1:0] req_type;
  logic                  modifier_pressed;
  logic [KEY_W-1:0]      pressed_key;
  logic [STAMP_W-1:0]    now_ms;
  logic [ENTRY_W-1:0]    entry_index;
  logic [POS_W-1:0]      key_position;
  logic [VALUE_W-1:0]    write_value;

  modport source (
    output valid, req_type, modifier_pressed, pressed_key, now_ms, entry_index,
           key_position, write_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, modifier_pressed, pressed_key, now_ms, entry_index,
           key_position, write_value,
    output ready
  );
endinterface

interface hsm_rsp_if import hsm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   hit;
  logic [HIT_INDEX_W-1:0] hit_index;
  logic                   capturing;

  modport source (output valid, hit, hit_index, capturing, input ready);
  modport sink (input valid, hit, hit_index, capturing, output ready);
endinterface

interface hsm_cfg_if import hsm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [TIMEOUT_W-1:0] timeout_ms;

  modport source (output valid, timeout_ms, input ready);
  modport sink (input valid, timeout_ms, output ready);
endinterface

`default_nettype wire

// ===== rtl/hsm_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none

module hsm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/hsm_walker.sv =====
// shortcut table walker: issues reads, compares keys, keeps lengths and last hit
`default_nettype none

module hsm_walker import hsm_pkg::*; #(
  parameter int unsigned MAX_SHORTCUTS = 16,
  parameter int unsigned MAX_SEQ_KEYS  = 8,
  parameter int unsigned KEY_CODE_BITS = 10,
  localparam int unsigned EW = (MAX_SHORTCUTS > 1) ? $clog2(MAX_SHORTCUTS) : 1,
  localparam int unsigned PW = $clog2(MAX_SEQ_KEYS),
  localparam int unsigned LW = $clog2(MAX_SEQ_KEYS + 1),
  localparam int unsigned AW = $clog2(MAX_SHORTCUTS * MAX_SEQ_KEYS),
  localparam int unsigned KW = KEY_CODE_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  walk_ctl_t     ctl_i,
  input  logic [KW-1:0] tab_rdata_i,
  input  logic [KW-1:0] cap_rdata_i,
  output logic [AW-1:0] tab_raddr_o,
  output logic [PW-1:0] cap_raddr_o,
  output walk_sts_t     sts_o
);

  logic [LW-1:0] len_q [MAX_SHORTCUTS];
  logic [LW-1:0] count_q;

  // issue stage
  logic          iss_q;
  logic [EW-1:0] ent_q;
  logic [PW-1:0] pos_q;
  logic [AW-1:0] base_q;
  logic          last_key;
  logic          last_ent;

  // compare stage
  logic          cmp_v_q;
  logic          cmp_last_q;
  logic          cmp_end_q;
  logic [EW-1:0] cmp_ent_q;
  logic          mism_q;
  logic          mism_nx;
  logic          hit_q;
  logic [EW-1:0] hit_ent_q;
  logic          done_q;

  assign last_key = (LW'(pos_q) + LW'(1)) == count_q;
  assign last_ent = ent_q == EW'(MAX_SHORTCUTS - 1);

  assign tab_raddr_o = base_q + AW'(pos_q);
  assign cap_raddr_o = pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < MAX_SHORTCUTS; e++) begin
        len_q[e] <= '0;
      end
    end else if (ctl_i.len_we) begin
      len_q[EW'(ctl_i.len_idx)] <= LW'(ctl_i.len_val);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q   <= 1'b0;
      cmp_v_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      cmp_v_q <= iss_q;
      done_q  <= cmp_v_q && cmp_end_q;
      if (ctl_i.start) begin
        iss_q <= 1'b1;
      end else if (iss_q && last_key && last_ent) begin
        iss_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_last_q <= last_key;
    cmp_end_q  <= last_key && last_ent;
    cmp_ent_q  <= ent_q;
    if (ctl_i.start) begin
      count_q <= LW'(ctl_i.count);
      ent_q   <= '0;
      pos_q   <= '0;
      base_q  <= '0;
    end else if (iss_q) begin
      if (last_key) begin
        pos_q  <= '0;
        base_q <= base_q + AW'(MAX_SEQ_KEYS);
        ent_q  <= ent_q + EW'(1);
      end else begin
        pos_q <= pos_q + PW'(1);
      end
    end
  end

  assign mism_nx = mism_q || (tab_rdata_i != cap_rdata_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mism_q <= 1'b0;
      hit_q  <= 1'b0;
    end else if (ctl_i.start) begin
      mism_q <= 1'b0;
      hit_q  <= 1'b0;
    end else if (cmp_v_q) begin
      if (cmp_last_q) begin
        mism_q <= 1'b0;
        if (!mism_nx && (len_q[cmp_ent_q] == count_q)) begin
          hit_q <= 1'b1;
        end
      end else begin
        mism_q <= mism_nx;
      end
    end
  end

  // later entries overwrite earlier ones, so the highest match remains
  always_ff @(posedge clk_i) begin
    if (cmp_v_q && cmp_last_q && !mism_nx && (len_q[cmp_ent_q] == count_q)) begin
      hit_ent_q <= cmp_ent_q;
    end
  end

  assign sts_o.done    = done_q;
  assign sts_o.hit     = hit_q;
  assign sts_o.hit_idx = ENT_MAX_W'(hit_ent_q);

endmodule

`default_nettype wire

// ===== rtl/hotkey_sequence_matcher.sv =====
// hotkey sequence matcher top level: capture control, table writes, result register
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+------------------------------------------------
//   cfg_i    | in  | valid / ready | timeout_ms
//   req_i    | in  | valid / ready | req_type, modifier_pressed, pressed_key, now_ms,
//            |     |               | entry_index, key_position, write_value
//   rsp_o    | out | valid / ready | hit, hit_index, capturing
//
// table writes, frames without timeout and frames whose capture cannot match load the
// result register directly; a frame that times out with a clean capture of n >= 2 keys
// walks the key table memory one key per cycle, through every entry, before it answers
// after reset the key table is swept to zero while req_i is held off; cfg_i is always ready
// req_i is taken only while idle and the result register is empty or being drained
`default_nettype none

module hotkey_sequence_matcher import hsm_pkg::*; #(
  parameter int unsigned MAX_SHORTCUTS = 16,
  parameter int unsigned MAX_SEQ_KEYS  = 8,
  parameter int unsigned KEY_CODE_BITS = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hsm_cfg_if.sink    cfg_i,
  hsm_req_if.sink    req_i,
  hsm_rsp_if.source  rsp_o
);

  localparam int unsigned PW = $clog2(MAX_SEQ_KEYS);
  localparam int unsigned LW = $clog2(MAX_SEQ_KEYS + 1);
  localparam int unsigned AW = $clog2(MAX_SHORTCUTS * MAX_SEQ_KEYS);
  localparam int unsigned KW = KEY_CODE_BITS;

  // control
  hsm_state_e state_q, state_d;
  logic [AW-1:0] clr_q;
  logic          clr_last;
  logic          clr_active;
  logic          req_ready;
  logic          req_acc;
  logic          out_free;
  logic          rsp_load_walk;

  // capture state
  logic [TIMEOUT_W-1:0] timeout_q;
  logic                 active_q;
  logic [LW-1:0]        count_q;
  logic                 ovf_q;
  logic [STAMP_W-1:0]   stamp_q;

  // frame evaluation
  logic               is_frame;
  logic               is_key;
  logic               is_len;
  logic [KW-1:0]      key_m;
  logic               act1;
  logic [STAMP_W-1:0] stamp1;
  logic [STAMP_W-1:0] stamp2;
  logic               append;
  logic               full;
  logic [LW-1:0]      cnt_app;
  logic               ovf_app;
  logic [STAMP_W-1:0] elapsed;
  logic               tmo;
  logic               act_new;
  logic               walk_start;

  // table writes
  logic          key_ok;
  logic          len_ok;
  logic [AW-1:0] key_addr;
  logic          tab_we;
  logic [AW-1:0] tab_waddr;
  logic [KW-1:0] tab_wdata;
  logic [LW-1:0] len_clamp;

  // memory and walker hookup
  logic [AW-1:0] tab_raddr;
  logic [KW-1:0] tab_rdata;
  logic [PW-1:0] cap_raddr;
  logic [KW-1:0] cap_rdata;
  logic          cap_we;
  walk_ctl_t     walk_ctl;
  walk_sts_t     walk_sts;

  // result register
  logic                   rsp_valid_q;
  logic                   rsp_hit_q;
  logic [HIT_INDEX_W-1:0] rsp_idx_q;
  logic                   rsp_cap_q;

  // configuration never stalls
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_i.valid) begin
      timeout_q <= cfg_i.timeout_ms;
    end
  end

  // ---------------------------------------------------------------------------
  // request decode and frame arithmetic
  // ---------------------------------------------------------------------------
  assign is_frame = req_i.req_type == REQ_FRAME;
  assign is_key   = req_i.req_type == REQ_KEY;
  assign is_len   = req_i.req_type == REQ_LEN;

  // key codes narrower or wider than the port are masked or zero-extended
  assign key_m = KW'(req_i.pressed_key);

  // a modifier press while idle opens capture and starts the timer
  assign act1   = active_q || req_i.modifier_pressed;
  assign stamp1 = (req_i.modifier_pressed && !active_q) ? req_i.now_ms : stamp_q;

  // each key while capturing restarts the timer, also once the buffer is full
  assign append  = act1 && (key_m != '0);
  assign full    = count_q == LW'(MAX_SEQ_KEYS);
  assign stamp2  = append ? req_i.now_ms : stamp1;
  assign cnt_app = (append && !full) ? count_q + LW'(1) : count_q;
  assign ovf_app = ovf_q || (append && full);

  // wrapping elapsed time, checked on every frame
  assign elapsed = req_i.now_ms - stamp2;
  assign tmo     = elapsed > STAMP_W'(timeout_q);
  assign act_new = act1 && !tmo;

  // only a clean capture of two keys or more can match anything
  assign walk_start = is_frame && tmo && !ovf_app && (cnt_app >= LW'(2));

  // ---------------------------------------------------------------------------
  // table write decode
  // ---------------------------------------------------------------------------
  assign key_ok   = (32'(req_i.entry_index) < 32'(MAX_SHORTCUTS)) &&
                    (32'(req_i.key_position) < 32'(MAX_SEQ_KEYS));
  assign len_ok   = 32'(req_i.entry_index) < 32'(MAX_SHORTCUTS);
  assign key_addr = AW'(32'(req_i.entry_index) * 32'(MAX_SEQ_KEYS) +
                        32'(req_i.key_position));
  assign len_clamp = (32'(req_i.write_value) > 32'(MAX_SEQ_KEYS)) ?
                     LW'(MAX_SEQ_KEYS) : LW'(req_i.write_value);

  // the reset sweep owns the write port while it runs
  assign tab_we    = clr_active || (req_acc && is_key && key_ok);
  assign tab_waddr = clr_active ? clr_q : key_addr;
  assign tab_wdata = clr_active ? '0 : KW'(req_i.write_value);

  assign cap_we = req_acc && is_frame && append && !full;

  assign walk_ctl.start   = req_acc && walk_start;
  assign walk_ctl.count   = CNT_MAX_W'(cnt_app);
  assign walk_ctl.len_we  = req_acc && is_len && len_ok;
  assign walk_ctl.len_idx = ENT_MAX_W'(req_i.entry_index);
  assign walk_ctl.len_val = CNT_MAX_W'(len_clamp);

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  assign out_free = !rsp_valid_q || rsp_o.ready;
  assign clr_last = clr_q == AW'(MAX_SHORTCUTS * MAX_SEQ_KEYS - 1);
  assign req_acc  = req_i.valid && req_ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_acc && walk_start) state_d = ST_WALK;
      end
      ST_WALK: begin
        if (walk_sts.done) state_d = ST_REPLY;
      end
      ST_REPLY: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    clr_active    = 1'b0;
    req_ready     = 1'b0;
    rsp_load_walk = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        clr_active = 1'b1;
      end
      ST_IDLE: begin
        req_ready = out_free;
      end
      ST_WALK: begin
        req_ready = 1'b0;
      end
      ST_REPLY: begin
        rsp_load_walk = out_free;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  assign req_i.ready = req_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (clr_active) begin
        clr_q <= clr_q + AW'(1);
      end
    end
  end

  // capture state moves only on an accepted frame; a timeout clears it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      count_q  <= '0;
      ovf_q    <= 1'b0;
      stamp_q  <= '0;
    end else if (req_acc && is_frame) begin
      active_q <= act_new;
      count_q  <= tmo ? '0 : cnt_app;
      ovf_q    <= tmo ? 1'b0 : ovf_app;
      stamp_q  <= stamp2;
    end
  end

  // ---------------------------------------------------------------------------
  // memories and walker
  // ---------------------------------------------------------------------------
  hsm_ram #(
    .WIDTH (KW),
    .DEPTH (MAX_SHORTCUTS * MAX_SEQ_KEYS)
  ) u_tab_ram (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (tab_waddr),
    .wdata_i (tab_wdata),
    .raddr_i (tab_raddr),
    .rdata_o (tab_rdata)
  );

  hsm_ram #(
    .WIDTH (KW),
    .DEPTH (MAX_SEQ_KEYS)
  ) u_cap_ram (
    .clk_i   (clk_i),
    .we_i    (cap_we),
    .waddr_i (PW'(count_q)),
    .wdata_i (key_m),
    .raddr_i (cap_raddr),
    .rdata_o (cap_rdata)
  );

  hsm_walker #(
    .MAX_SHORTCUTS (MAX_SHORTCUTS),
    .MAX_SEQ_KEYS  (MAX_SEQ_KEYS),
    .KEY_CODE_BITS (KEY_CODE_BITS)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (walk_ctl),
    .tab_rdata_i (tab_rdata),
    .cap_rdata_i (cap_rdata),
    .tab_raddr_o (tab_raddr),
    .cap_raddr_o (cap_raddr),
    .sts_o       (walk_sts)
  );

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (rsp_load_walk || (req_acc && !walk_start)) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load_walk) begin
      rsp_hit_q <= walk_sts.hit;
      rsp_idx_q <= walk_sts.hit ? HIT_INDEX_W'(walk_sts.hit_idx) : '0;
      rsp_cap_q <= 1'b0;
    end else if (req_acc && !walk_start) begin
      // non-frame transactions report the capture flag as it stands
      rsp_hit_q <= 1'b0;
      rsp_idx_q <= '0;
      rsp_cap_q <= is_frame ? act_new : active_q;
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.hit       = rsp_hit_q;
  assign rsp_o.hit_index = rsp_idx_q;
  assign rsp_o.capturing = rsp_cap_q;

endmodule

`default_nettype wire

// ===== rtl/hsm_checker.sv =====
// port-level checks for the hotkey sequence matcher, bound to the top level
`default_nettype none
`include "hotkey_sequence_matcher_macros.svh"

module hsm_checker import hsm_pkg::*; (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   req_valid_i,
  input wire logic                   req_ready_i,
  input wire logic                   rsp_valid_i,
  input wire logic                   rsp_ready_i,
  input wire logic                   hit_i,
  input wire logic [HIT_INDEX_W-1:0] hit_index_i,
  input wire logic                   capturing_i
);

  // a stalled result holds
  `HSM_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(hit_i) && $stable(hit_index_i) && $stable(capturing_i))

  // a new transaction is taken only when the result register has room
  `HSM_ASSERT_IMPL(a_req_room, clk_i, rst_ni, req_valid_i && req_ready_i, !rsp_valid_i || rsp_ready_i)

  // no hit reports entry zero
  `HSM_ASSERT_IMPL(a_idx_zero, clk_i, rst_ni, rsp_valid_i && !hit_i, hit_index_i == '0)

  // a match always ends capture
  `HSM_ASSERT_IMPL(a_hit_clears, clk_i, rst_ni, rsp_valid_i && hit_i, !capturing_i)

endmodule

bind hotkey_sequence_matcher hsm_checker u_hsm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .hit_i       (rsp_o.hit),
  .hit_index_i (rsp_o.hit_index),
  .capturing_i (rsp_o.capturing)
);

`default_nettype wire
